// ===== src/ats_pkg.sv =====
// Types and constants shared by the assembler token scanner modules.
`timescale 1ns / 1ps
`default_nettype none
package ats_pkg;

	localparam int MAX_TOKENS  = 3;
	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [3:0] {
		KIND_COMMA   = 4'd0,
		KIND_OPEN    = 4'd1,
		KIND_CLOSE   = 4'd2,
		KIND_COLON   = 4'd3,
		KIND_PLUS    = 4'd4,
		KIND_MINUS   = 4'd5,
		KIND_NEWLINE = 4'd6,
		KIND_HEX     = 4'd7,
		KIND_DEC     = 4'd8,
		KIND_IDENT   = 4'd9,
		KIND_UNKNOWN = 4'd10,
		KIND_END     = 4'd11
	} kind_t;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_NEWLINE,
		MODE_ZERO,
		MODE_ZERO_X,
		MODE_HEX,
		MODE_DEC,
		MODE_IDENT
	} mode_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] start;
		logic [15:0] length;
	} token_t;

	// All tokens caused by one source byte, slot 0 first.
	typedef struct packed {
		logic [1:0]                  count;
		token_t [MAX_TOKENS-1:0]     tok;
	} group_t;

	function automatic group_t append(input group_t g, input kind_t kind,
			input logic [15:0] start, input logic [15:0] length);
		group_t r;
		r = g;
		if (r.count != 2'(MAX_TOKENS)) begin
			r.tok[r.count].kind   = kind;
			r.tok[r.count].start  = start;
			r.tok[r.count].length = length;
			r.count = r.count + 2'd1;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== src/ats_if.sv =====
// Handshake channels for source bytes and for tokens.
`timescale 1ns / 1ps
`default_nettype none
interface ats_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       final_char;

	modport source(output valid, output char_code, output final_char, input ready);
	modport sink(input valid, input char_code, input final_char, output ready);
endinterface

interface ats_token_if;
	logic        valid;
	logic        ready;
	logic [3:0]  token_kind;
	logic [15:0] token_start;
	logic [15:0] token_length;
	logic        run_end;

	modport source(output valid, output token_kind, output token_start,
		output token_length, output run_end, input ready);
	modport sink(input valid, input token_kind, input token_start,
		input token_length, input run_end, output ready);
endinterface
`default_nettype wire

// ===== src/ats_front.sv =====
// Front end: accepts source bytes, tracks the scan mode and forms token groups.
`timescale 1ns / 1ps
`default_nettype none
module ats_front #(
	parameter int MAX_SOURCE_BYTES = 65536
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	ats_byte_if.sink         text,
	output logic             push,
	output ats_pkg::group_t  push_group,
	input  wire logic        queue_full
);
	import ats_pkg::*;

	localparam int POS_W = $clog2(MAX_SOURCE_BYTES);

	mode_t             mode_q, mode_n;
	logic [POS_W-1:0]  begin_q, begin_n;
	logic [POS_W-1:0]  pos_q, pos_n;
	logic [15:0]       len_q, len_n;
	logic [POS_W-1:0]  pos_inc;
	logic [POS_W-1:0]  begin_inc;
	logic [15:0]       len_grow;
	logic              accept;
	logic              keep;
	logic [7:0]        c;
	logic              is_digit, is_letter, is_nl, is_hexch, is_x, is_space;
	logic              is_punct;
	kind_t             punct_kind;
	group_t            g;

	function automatic logic [15:0] low16(input logic [POS_W-1:0] p);
		logic [POS_W+15:0] e;
		e = {16'b0, p};
		return e[15:0];
	endfunction

	function automatic logic [POS_W-1:0] wrap_inc(input logic [POS_W-1:0] p);
		logic [POS_W-1:0] r;
		if (p == POS_W'(MAX_SOURCE_BYTES - 1)) begin
			r = '0;
		end else begin
			r = p + 1'b1;
		end
		return r;
	endfunction

	assign c          = text.char_code;
	assign text.ready = !queue_full;
	assign accept     = text.valid && text.ready;

	always_comb begin
		is_digit  = (c >= 8'h30) && (c <= 8'h39);
		is_letter = ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a))
			|| (c == 8'h5f);
		is_nl     = (c == 8'h0d) || (c == 8'h0a);
		is_x      = (c == 8'h78) || (c == 8'h58);
		is_hexch  = is_digit || ((c >= 8'h61) && (c <= 8'h66))
			|| ((c >= 8'h41) && (c <= 8'h46)) || is_x;
		is_space  = (c == 8'h20) || (c == 8'h09);
		is_punct  = 1'b1;
		unique case (c)
			8'h2c:   punct_kind = KIND_COMMA;
			8'h5b:   punct_kind = KIND_OPEN;
			8'h5d:   punct_kind = KIND_CLOSE;
			8'h3a:   punct_kind = KIND_COLON;
			8'h2b:   punct_kind = KIND_PLUS;
			8'h2d:   punct_kind = KIND_MINUS;
			default: begin
				punct_kind = KIND_UNKNOWN;
				is_punct   = 1'b0;
			end
		endcase
	end

	always_comb begin
		g        = '0;
		keep     = 1'b0;
		mode_n   = mode_q;
		begin_n  = begin_q;
		len_n    = len_q;
		len_grow = (len_q == 16'hffff) ? len_q : len_q + 16'd1;

		unique case (mode_q)
			MODE_IDLE: begin
			end
			MODE_NEWLINE: begin
				if (is_nl) keep = 1'b1;
				else g = append(g, KIND_NEWLINE, low16(begin_q), len_q);
			end
			MODE_ZERO: begin
				if (is_x) begin
					mode_n = MODE_ZERO_X;
					keep   = 1'b1;
				end else if (is_digit) begin
					mode_n = MODE_DEC;
					keep   = 1'b1;
				end else begin
					g = append(g, KIND_DEC, low16(begin_q), len_q);
				end
			end
			MODE_ZERO_X: begin
				if (is_hexch) begin
					mode_n = MODE_HEX;
					keep   = 1'b1;
				end else begin
					g = append(g, KIND_HEX, low16(begin_q), len_q);
				end
			end
			MODE_HEX: begin
				if (is_hexch) keep = 1'b1;
				else g = append(g, KIND_HEX, low16(begin_q), len_q);
			end
			MODE_DEC: begin
				if (is_digit) keep = 1'b1;
				else g = append(g, KIND_DEC, low16(begin_q), len_q);
			end
			MODE_IDENT: begin
				if (is_letter || is_digit) keep = 1'b1;
				else g = append(g, KIND_IDENT, low16(begin_q), len_q);
			end
			default: begin
			end
		endcase

		if (keep) begin
			len_n = len_grow;
		end else begin
			mode_n = MODE_IDLE;
			len_n  = '0;
			priority if (is_space) begin
			end else if (is_punct) begin
				g = append(g, punct_kind, low16(pos_q), 16'd1);
			end else if (is_nl) begin
				mode_n  = MODE_NEWLINE;
				begin_n = pos_q;
				len_n   = 16'd1;
			end else if (c == 8'h30) begin
				mode_n  = MODE_ZERO;
				begin_n = pos_q;
				len_n   = 16'd1;
			end else if (is_digit) begin
				mode_n  = MODE_DEC;
				begin_n = pos_q;
				len_n   = 16'd1;
			end else if (is_letter) begin
				mode_n  = MODE_IDENT;
				begin_n = pos_q;
				len_n   = 16'd1;
			end else begin
				g = append(g, KIND_UNKNOWN, low16(pos_q), 16'd1);
			end
		end

		pos_inc   = wrap_inc(pos_q);
		begin_inc = wrap_inc(begin_n);
		pos_n     = pos_inc;

		if (text.final_char) begin
			unique case (mode_n)
				MODE_NEWLINE: g = append(g, KIND_NEWLINE, low16(begin_n), len_n);
				MODE_ZERO,
				MODE_DEC:     g = append(g, KIND_DEC, low16(begin_n), len_n);
				MODE_ZERO_X: begin
					// A bare "0x" at the end is a decimal zero and an identifier x.
					g = append(g, KIND_DEC, low16(begin_n), 16'd1);
					g = append(g, KIND_IDENT, low16(begin_inc), 16'd1);
				end
				MODE_HEX:     g = append(g, KIND_HEX, low16(begin_n), len_n);
				MODE_IDENT:   g = append(g, KIND_IDENT, low16(begin_n), len_n);
				default: begin
				end
			endcase
			g       = append(g, KIND_END, low16(pos_inc), 16'd0);
			mode_n  = MODE_IDLE;
			begin_n = '0;
			pos_n   = '0;
			len_n   = '0;
		end
	end

	assign push       = accept && (g.count != 2'd0);
	assign push_group = g;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			begin_q <= '0;
			pos_q   <= '0;
			len_q   <= '0;
		end else if (accept) begin
			mode_q  <= mode_n;
			begin_q <= begin_n;
			pos_q   <= pos_n;
			len_q   <= len_n;
		end
	end

endmodule
`default_nettype wire

// ===== src/ats_queue.sv =====
// Short queue of token groups between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none
module ats_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire ats_pkg::group_t  push_group,
	output logic                  full,
	input  wire logic             pop,
	output ats_pkg::group_t       head,
	output logic                  empty
);
	import ats_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	group_t                 mem [QUEUE_DEPTH];
	logic [PTR_W-1:0]       wr_ptr_q;
	logic [PTR_W-1:0]       rd_ptr_q;
	logic [PTR_W:0]         cnt_q;
	logic                   do_push;
	logic                   do_pop;

	assign full    = (cnt_q == (PTR_W+1)'(QUEUE_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_group;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== src/ats_back.sv =====
// Back end: sends the tokens of each queued group one word at a time.
`timescale 1ns / 1ps
`default_nettype none
module ats_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire ats_pkg::group_t  head,
	input  wire logic             empty,
	output logic                  pop,
	ats_token_if.source           tokens
);
	import ats_pkg::*;

	logic [1:0]  sub_q;
	logic        out_valid_q;
	logic [3:0]  kind_q;
	logic [15:0] start_q;
	logic [15:0] length_q;
	logic        run_end_q;
	logic        load;
	logic        last;
	token_t      cur;

	assign cur  = head.tok[sub_q];
	assign last = (sub_q == head.count - 2'd1);
	assign load = !empty && (!out_valid_q || tokens.ready);
	assign pop  = load && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				sub_q       <= last ? 2'd0 : sub_q + 2'd1;
			end else if (tokens.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q    <= cur.kind;
			start_q   <= cur.start;
			length_q  <= cur.length;
			run_end_q <= last;
		end
	end

	assign tokens.valid        = out_valid_q;
	assign tokens.token_kind   = kind_q;
	assign tokens.token_start  = start_q;
	assign tokens.token_length = length_q;
	assign tokens.run_end      = run_end_q;

endmodule
`default_nettype wire

// ===== src/assembler_token_scanner_unit.sv =====
// Top level of the assembler token scanner.
//
// The text channel takes one source byte per word with a flag that marks the
// last byte of a source. The tokens channel gives one token per word: kind,
// start offset, length and a run_end flag on the last token a byte caused.
// A byte taken at a clock edge is scanned in the cycle before that edge and
// its tokens enter the queue at that edge; the first of them is loaded into
// the output register once earlier groups are sent and the register is free,
// and is offered from then on; the rest follow one per cycle while the
// receiver takes them. The text port can take a new byte whenever the queue
// is not full. A byte that ends a token and starts another may cause two tokens, and a final byte up to three.
// A four-group queue between the scanner and the output register absorbs
// those bursts, so text.ready falls only when the queue is full.
// When the receiver stalls, the output word holds and the queue fills; the
// scanner then stops taking bytes. Reset empties the queue, drops the output
// word and puts the scanner idle at offset zero; no clearing pass is needed.
// After a final byte the offset restarts at zero for the next source.
`timescale 1ns / 1ps
`default_nettype none
module assembler_token_scanner_unit #(
	parameter int MAX_SOURCE_BYTES = 65536
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	ats_byte_if.sink     text,
	ats_token_if.source  tokens
);
	import ats_pkg::*;

	logic    push;
	group_t  push_group;
	logic    full;
	logic    pop;
	group_t  head;
	logic    empty;

	ats_front #(
		.MAX_SOURCE_BYTES(MAX_SOURCE_BYTES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.text       (text),
		.push       (push),
		.push_group (push_group),
		.queue_full (full)
	);

	ats_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_group (push_group),
		.full       (full),
		.pop        (pop),
		.head       (head),
		.empty      (empty)
	);

	ats_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.empty  (empty),
		.pop    (pop),
		.tokens (tokens)
	);

endmodule
`default_nettype wire
